// ===== design/pulse_tone_synth_envelope_macros.svh =====
// -----------------------------------------------------------------------------
// Pulse tone synth assertion macros
// Shared concurrent assertion forms for the synth checker.
// -----------------------------------------------------------------------------
`ifndef PULSE_TONE_SYNTH_ENVELOPE_MACROS_SVH
`define PULSE_TONE_SYNTH_ENVELOPE_MACROS_SVH

// same-cycle implication
`define PTSE_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptse assertion failed");

// next-cycle implication
`define PTSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptse assertion failed");

`endif

// ===== design/ptse_pkg.sv =====
// -----------------------------------------------------------------------------
// Pulse tone synth package
// Types, constants and table builders shared by the synth modules.
// -----------------------------------------------------------------------------
package ptse_pkg;

  localparam int MAX_HARMONICS  = 128;
  localparam int COS_TABLE_BITS = 10;
  localparam int PHASE_BITS     = 32;

  localparam int QTR_BITS  = COS_TABLE_BITS - 2;
  localparam int QTR_SIZE  = 2 ** QTR_BITS;
  localparam int HARM_W    = $clog2(MAX_HARMONICS + 1);
  localparam int DIV_DVD_W = 40;
  localparam int DIV_DVS_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

  localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

  localparam longint Q30_ONE         = 64'sd1073741824;
  localparam longint PI_HALF_Q30     = 64'sd1686629713;
  localparam longint TWO_OVER_PI_Q15 = 64'sd20861;
  localparam longint PW_PHASE        = 64'sd794568950;

  typedef struct packed {
    logic        action;
    logic [30:0] phase_step;
    logic [23:0] note_length;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               note_active;
    logic               note_last;
  } out_t;

  typedef struct packed {
    logic [15:0] attack_len;
    logic [15:0] release_len;
    logic [15:0] decay_level;
    logic [15:0] amplitude;
    logic [31:0] harmonic_limit_step;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_ATTACK_LEN     = 3'd0,
    REG_RELEASE_LEN    = 3'd1,
    REG_DECAY_LEVEL    = 3'd2,
    REG_AMPLITUDE      = 3'd3,
    REG_HARMONIC_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic hdiv_start;
    logic loop_start;
    logic gain;
    logic mult;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic playing;
    logic div_busy;
    logic loop_busy;
  } status_t;

  // cosine of a quarter-wave angle q/2^30 * pi/2, Q15
  function automatic longint quarter_cos(longint q);
    longint x;
    longint x2;
    longint t;
    x  = (q * PI_HALF_Q30) >>> 30;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE - x2 / 90;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 56;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 30;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 12;
    t  = Q30_ONE - ((x2 * t) >>> 30) / 2;
    if (t < 0) t = 0;
    return (t + 64'sd16384) >>> 15;
  endfunction

  // full-table cosine entry by quadrant folding
  function automatic longint cos_entry(longint idx);
    longint quad;
    longint low;
    longint sh;
    quad = idx >> QTR_BITS;
    low  = idx & longint'(QTR_SIZE - 1);
    sh   = 30 - QTR_BITS;
    case (quad)
      0:       return quarter_cos(low << sh);
      1:       return -quarter_cos((longint'(QTR_SIZE) - low) << sh);
      2:       return -quarter_cos(low << sh);
      default: return quarter_cos((longint'(QTR_SIZE) - low) << sh);
    endcase
  endfunction

  // numerator of harmonic coefficient k, before the divide by k
  function automatic longint coef_num(int k);
    longint p;
    p = (longint'(k) * PW_PHASE - Q30_ONE) & 64'sh0FFFFFFFF;
    return TWO_OVER_PI_Q15 * cos_entry(p >> (32 - COS_TABLE_BITS));
  endfunction

endpackage

// ===== design/pulse_tone_synth_envelope.sv =====
// -----------------------------------------------------------------------------
// Pulse tone synth with envelope
// Band-limited pulse oscillator, additive harmonics, ADSR-style gain.
// -----------------------------------------------------------------------------
// While a note plays, a word runs two passes of the shared divider: the harmonic
// count h (up to 128), then the envelope ramp beside the one-harmonic-per-cycle
// MAC. Idle words go from evaluation straight to output. One word is in work at
// a time; the next is taken in the cycle after the result is loaded, later while
// an older result is still held.
// Reset (rst, synchronous): config registers to defaults, note idle.
// -----------------------------------------------------------------------------
module pulse_tone_synth_envelope import ptse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  cmd_t     cmd;
  status_t  status;
  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_len          <= 16'd240;
      cfg.release_len         <= 16'd1920;
      cfg.decay_level         <= 16'd22938;
      cfg.amplitude           <= 16'd22938;
      cfg.harmonic_limit_step <= 32'h4000_0000;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ATTACK_LEN:     cfg.attack_len          <= pwdata[15:0];
        REG_RELEASE_LEN:    cfg.release_len         <= pwdata[15:0];
        REG_DECAY_LEVEL:    cfg.decay_level         <= pwdata[15:0];
        REG_AMPLITUDE:      cfg.amplitude           <= pwdata[15:0];
        REG_HARMONIC_LIMIT: cfg.harmonic_limit_step <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ATTACK_LEN:     prdata = {16'd0, cfg.attack_len};
      REG_RELEASE_LEN:    prdata = {16'd0, cfg.release_len};
      REG_DECAY_LEVEL:    prdata = {16'd0, cfg.decay_level};
      REG_AMPLITUDE:      prdata = {16'd0, cfg.amplitude};
      REG_HARMONIC_LIMIT: prdata = cfg.harmonic_limit_step;
      default:            prdata = '0;
    endcase
  end

  ptse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ptse_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== design/ptse_div.sv =====
// -----------------------------------------------------------------------------
// Pulse tone synth divider
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module ptse_div import ptse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_DVS_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_DVD_W-1:0] quotient
);

  logic [DIV_DVS_W-1:0] rem;
  logic [DIV_DVS_W-1:0] dvs;
  logic [DIV_DVD_W-1:0] quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DVS_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_DVD_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? DIV_DVS_W'(trial - {1'b0, dvs}) : trial[DIV_DVS_W-1:0];
      quo <= {quo[DIV_DVD_W-2:0], fits};
    end
  end

  assign busy     = cnt != '0;
  assign quotient = quo;

endmodule

// ===== design/ptse_ctrl.sv =====
// -----------------------------------------------------------------------------
// Pulse tone synth controller
// Sequences one word through divide, harmonic sum, gain and output.
// -----------------------------------------------------------------------------
module ptse_ctrl import ptse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_HDIV = 7'b0000100,
    S_LOOP = 7'b0001000,
    S_GAIN = 7'b0010000,
    S_MULT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.playing) begin
          cmd.eval       = 1'b1;
          cmd.hdiv_start = 1'b1;
          state_next     = S_HDIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_HDIV: begin
        if (!status.div_busy) begin
          cmd.loop_start = 1'b1;
          state_next     = S_LOOP;
        end
      end
      S_LOOP: begin
        if (!status.div_busy && !status.loop_busy) state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = state == S_IDLE;

endmodule

// ===== design/ptse_dp.sv =====
// -----------------------------------------------------------------------------
// Pulse tone synth datapath
// Note state, envelope operands, harmonic pipeline, gain and output word.
// -----------------------------------------------------------------------------
module ptse_dp import ptse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  in_t     in_data,
  input  cfg_t    cfg,
  input  cmd_t    cmd,
  output status_t status,
  output out_t    out_data
);

  typedef enum logic [1:0] {
    ENV_ATTACK,
    ENV_RELEASE,
    ENV_MIDDLE,
    ENV_FLAT
  } env_seg_t;

  // constant tables
  logic [15:0]        qtab     [QTR_SIZE+1];
  logic signed [31:0] coef_tab [MAX_HARMONICS+1];

  for (genvar j = 0; j <= QTR_SIZE; j++) begin : g_qtab
    localparam longint QVal = quarter_cos(longint'(j) << (30 - QTR_BITS));
    assign qtab[j] = 16'(QVal);
  end

  for (genvar k = 0; k <= MAX_HARMONICS; k++) begin : g_coef
    localparam longint CNum = (k == 0) ? 64'sd0 : coef_num(k);
    localparam longint CVal = CNum / ((k == 0) ? 1 : k);
    assign coef_tab[k] = 32'(CVal);
  end

  // note state
  logic [23:0] sample_index;
  logic [23:0] length_store;
  logic [31:0] base_phase;
  logic [31:0] step_store;
  logic        playing;
  logic        last;

  assign last = (sample_index + 24'd1) == length_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      length_store <= '0;
      base_phase   <= '0;
      step_store   <= '0;
      playing      <= 1'b0;
    end else if (cmd.load) begin
      if (in_data.action) begin
        step_store   <= {1'b0, in_data.phase_step} & PHASE_MASK;
        length_store <= in_data.note_length;
        sample_index <= '0;
        base_phase   <= '0;
        playing      <= in_data.note_length != '0;
      end
    end else if (cmd.emit && playing) begin
      sample_index <= sample_index + 24'd1;
      base_phase   <= base_phase + step_store;
      if (last) playing <= 1'b0;
    end
  end

  // envelope segment and divide operands
  logic [15:0] dsat;
  logic [15:0] asat;
  logic        in_attack;
  logic        in_release;
  logic [25:0] mid_w;
  logic        mid_pos;
  env_seg_t    env_seg;
  logic [15:0] env_a;
  logic [23:0] env_b;
  logic [23:0] env_dvs;

  assign dsat       = (cfg.decay_level > 16'h8000) ? 16'h8000 : cfg.decay_level;
  assign asat       = (cfg.amplitude > 16'h8000) ? 16'h8000 : cfg.amplitude;
  assign in_attack  = sample_index < {8'd0, cfg.attack_len};
  assign in_release = ({1'b0, sample_index} + {9'd0, cfg.release_len}) > {1'b0, length_store};
  assign mid_w      = {2'b0, length_store} - {10'd0, cfg.attack_len} - {10'd0, cfg.release_len};
  assign mid_pos    = !mid_w[25] && (mid_w != '0);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (in_attack) begin
        env_seg <= ENV_ATTACK;
        env_a   <= 16'h8000;
        env_b   <= sample_index;
        env_dvs <= {8'd0, cfg.attack_len};
      end else if (in_release) begin
        env_seg <= ENV_RELEASE;
        env_a   <= dsat;
        env_b   <= length_store - sample_index;
        env_dvs <= {8'd0, cfg.release_len};
      end else if (mid_pos) begin
        env_seg <= ENV_MIDDLE;
        env_a   <= 16'h8000 - dsat;
        env_b   <= sample_index - {8'd0, cfg.attack_len};
        env_dvs <= mid_w[23:0];
      end else begin
        env_seg <= ENV_FLAT;
        env_a   <= '0;
        env_b   <= '0;
        env_dvs <= 24'd1;
      end
    end
  end

  // shared divider: harmonic count first, then the envelope ramp
  logic [DIV_DVD_W-1:0] env_prod;
  logic [DIV_DVD_W-1:0] div_dvd;
  logic [DIV_DVS_W-1:0] div_dvs;
  logic [DIV_DVD_W-1:0] div_q;
  logic                 div_busy;

  assign env_prod = {24'd0, env_a} * {16'd0, env_b};
  assign div_dvd  = cmd.hdiv_start ? {8'd0, cfg.harmonic_limit_step} : env_prod;
  assign div_dvs  = cmd.hdiv_start ? step_store : {8'd0, env_dvs};

  ptse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.hdiv_start | cmd.loop_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  logic [HARM_W-1:0] h_calc;

  always_comb begin
    if (step_store == '0) begin
      h_calc = '0;
    end else if (div_q > DIV_DVD_W'(MAX_HARMONICS)) begin
      h_calc = HARM_W'(MAX_HARMONICS);
    end else begin
      h_calc = div_q[HARM_W-1:0];
    end
  end

  // harmonic pipeline: phase, table read, multiply, accumulate
  logic                 run;
  logic [HARM_W-1:0]    k_cnt;
  logic [HARM_W-1:0]    h_reg;
  logic [31:0]          ph;
  logic                 s1_valid;
  logic [31:0]          s1_ph;
  logic [HARM_W-1:0]    s1_k;
  logic                 s2_valid;
  logic signed [16:0]   s2_cos;
  logic signed [31:0]   s2_coef;
  logic                 s3_valid;
  logic signed [47:0]   s3_prod;
  logic signed [49:0]   acc;

  logic [COS_TABLE_BITS-1:0] cidx;
  logic [1:0]                quad;
  logic [QTR_BITS:0]         qaddr;
  logic [15:0]               qmag;
  logic signed [16:0]        cosv;

  assign cidx  = s1_ph[31 -: COS_TABLE_BITS];
  assign quad  = cidx[COS_TABLE_BITS-1 -: 2];
  assign qaddr = quad[0] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, cidx[QTR_BITS-1:0]})
                         : {1'b0, cidx[QTR_BITS-1:0]};
  assign qmag  = qtab[qaddr];
  assign cosv  = (quad[1] ^ quad[0]) ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (cmd.loop_start) begin
        run <= h_calc != '0;
      end else if (run && (k_cnt == h_reg)) begin
        run <= 1'b0;
      end
      s1_valid <= run;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.loop_start) begin
      ph    <= base_phase;
      k_cnt <= HARM_W'(1);
      h_reg <= h_calc;
    end else if (run) begin
      ph    <= ph + base_phase;
      k_cnt <= k_cnt + 1'b1;
    end
    s1_ph   <= ph;
    s1_k    <= k_cnt;
    s2_cos  <= cosv;
    s2_coef <= coef_tab[s1_k];
    s3_prod <= 48'(s2_coef) * 48'(s2_cos);
    if (cmd.loop_start) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= acc + 50'(s3_prod);
    end
  end

  // gain and final scaling
  logic [15:0]        env;
  logic signed [35:0] w30;
  logic [31:0]        g_prod;
  logic [16:0]        g;
  logic signed [53:0] s_prod;
  logic signed [23:0] s_round;
  logic signed [15:0] s_sat;

  always_comb begin
    case (env_seg) inside
      ENV_ATTACK, ENV_RELEASE: env = div_q[15:0];
      ENV_MIDDLE:              env = 16'h8000 - div_q[15:0];
      default:                 env = 16'h8000;
    endcase
  end

  assign g       = 17'((g_prod + 32'd16384) >> 15);
  assign s_round = 24'((s_prod + 54'sd536870912) >>> 30);

  always_comb begin
    if (s_round > 24'sd32767) begin
      s_sat = 16'sh7FFF;
    end else if (s_round < -24'sd32768) begin
      s_sat = -16'sh8000;
    end else begin
      s_sat = s_round[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      w30    <= 36'((acc + 50'sd16384) >>> 15);
      g_prod <= {16'd0, asat} * {16'd0, env};
    end
    if (cmd.mult) begin
      s_prod <= 54'(w30) * 54'($signed({1'b0, g}));
    end
    if (cmd.emit) begin
      if (playing) begin
        out_data.sample_out  <= s_sat;
        out_data.note_active <= 1'b1;
        out_data.note_last   <= last;
      end else begin
        out_data <= '0;
      end
    end
  end

  assign status.playing   = playing;
  assign status.div_busy  = div_busy;
  assign status.loop_busy = run | s1_valid | s2_valid | s3_valid;

endmodule

// ===== design/ptse_chk.sv =====
// -----------------------------------------------------------------------------
// Pulse tone synth checker
// Port-level assertions, bound to the synth top level.
// -----------------------------------------------------------------------------
`include "pulse_tone_synth_envelope_macros.svh"

module ptse_chk import ptse_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `PTSE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PTSE_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_data))
  `PTSE_ASSERT_NEXT(a_one_word, clk, rst, in_valid && in_ready, !in_ready)
  `PTSE_ASSERT_IMPL(a_idle_silent, clk, rst, out_valid && !out_data.note_active, (out_data.sample_out == 16'sd0) && !out_data.note_last)

endmodule

bind pulse_tone_synth_envelope ptse_chk u_chk (.*);

// ===== verif/tb_pulse_tone_synth_envelope.sv =====
// -----------------------------------------------------------------------------
// Pulse tone synth envelope testbench
// Drives note starts and sample ticks through a valid/ready stream, programs
// the envelope and band registers over APB between phases, and checks every
// sample against a bit-exact predictor of the oscillator and envelope.
// -----------------------------------------------------------------------------
module tb_pulse_tone_synth_envelope;
  import ptse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class synth_scoreboard;
    longint cos_tab[1024];
    longint coef[MAX_HARMONICS + 1];
    logic [15:0] attack_len, release_len, decay_level, amplitude;
    logic [31:0] harm_limit;
    logic [31:0] idx, len, base_phase, step;
    bit playing;
    out_t sample_q[$];
    int errors;

    function longint qcos(longint q);
      longint x, x2, t;
      x  = (q * PI_HALF_Q30) >>> 30;
      x2 = (x * x) >>> 30;
      t  = Q30_ONE - x2 / 90;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 56;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 30;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 12;
      t  = Q30_ONE - ((x2 * t) >>> 30) / 2;
      if (t < 0) t = 0;
      return (t + 16384) >>> 15;
    endfunction

    function longint wave_cos(logic [31:0] p);
      longint q;
      q = longint'(p[29:0]);
      case (p[31:30])
        2'd0: return qcos(q);
        2'd1: return -qcos(64'd1073741824 - q);
        2'd2: return -qcos(q);
        default: return qcos(64'd1073741824 - q);
      endcase
    endfunction

    function new();
      logic [31:0] p;
      for (int i = 0; i < 1024; i++) cos_tab[i] = wave_cos(32'(i) << 22);
      coef[0] = 0;
      for (int k = 1; k <= MAX_HARMONICS; k++) begin
        p = 32'(k) * 32'd794568950 - 32'h4000_0000;
        coef[k] = (TWO_OVER_PI_Q15 * cos_tab[p[31:22]]) / longint'(k);
      end
      attack_len = 240; release_len = 1920; decay_level = 22938; amplitude = 22938;
      harm_limit = 32'h4000_0000;
      idx = 0; len = 0; base_phase = 0; step = 0; playing = 0; errors = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_ATTACK_LEN:     attack_len  = v[15:0];
        REG_RELEASE_LEN:    release_len = v[15:0];
        REG_DECAY_LEVEL:    decay_level = v[15:0];
        REG_AMPLITUDE:      amplitude   = v[15:0];
        REG_HARMONIC_LIMIT: harm_limit  = v;
        default: ;
      endcase
    endfunction

    function void note_input(in_t w);
      out_t o;
      longint h, wsum, w30, i, l, a, r, d, env, g, s, mid;
      logic [31:0] ph;
      bit last;
      if (w.action) begin
        step = {1'b0, w.phase_step} & PHASE_MASK;
        len = {8'd0, w.note_length};
        idx = 0; base_phase = 0;
        playing = (w.note_length != 0);
      end
      o = '0;
      if (playing) begin
        h = 0;
        if (step != 0) begin
          h = longint'(harm_limit) / longint'(step);
          if (h > MAX_HARMONICS) h = MAX_HARMONICS;
        end
        wsum = 0; ph = 0;
        for (int k = 1; k <= h; k++) begin
          ph += base_phase;
          wsum += coef[k] * cos_tab[ph[31:22]];
        end
        w30 = (wsum + 16384) >>> 15;
        i = idx; l = len; a = attack_len; r = release_len;
        d = (decay_level > 32768) ? 32768 : decay_level;
        if (i < a) env = (i * 32768) / a;
        else if (i > l - r) env = (r != 0) ? (d * (l - i)) / r : 0;
        else begin
          mid = l - a - r;
          env = (mid > 0) ? 32768 - ((32768 - d) * (i - a)) / mid : 32768;
        end
        g = (longint'((amplitude > 32768) ? 32768 : amplitude) * env + 16384) >>> 15;
        s = (w30 * g + (64'sd1 << 29)) >>> 30;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        last = (idx + 1 == len);
        o.sample_out = 16'(s);
        o.note_active = 1;
        o.note_last = last;
        idx = (idx + 1) & 32'hFF_FFFF;
        base_phase += step;
        if (last) playing = 0;
      end
      sample_q.push_back(o);
    endfunction

    function void check(out_t got);
      out_t exp_s;
      if (sample_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample word %h", got);
        return;
      end
      exp_s = sample_q.pop_front();
      if (got.sample_out !== exp_s.sample_out || got.note_active !== exp_s.note_active ||
          got.note_last !== exp_s.note_last) begin
        errors++;
        if (errors <= 10)
          $display("sample mismatch: exp %0d/%b/%b got %0d/%b/%b",
                   exp_s.sample_out, exp_s.note_active, exp_s.note_last,
                   got.sample_out, got.note_active, got.note_last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int send_idle = 17;
  int recv_idle = 62;
  synth_scoreboard sb = new();

  pulse_tone_synth_envelope i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check(out_data);
    end
  end

  // valid stays up between back-to-back words; drop it only to idle
  task automatic send_word(logic act, logic [30:0] stp, logic [23:0] nlen);
    in_t w;
    w.action = act; w.phase_step = stp; w.note_length = nlen;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(r) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    sb.set_reg(r, v);
  endtask

  // drop valid and hold until every sample is back, then pause before the next phase
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.sample_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] a, logic [31:0] r, logic [31:0] d,
                              logic [31:0] g, logic [31:0] lim);
    write_reg(REG_ATTACK_LEN, a);
    write_reg(REG_RELEASE_LEN, r);
    write_reg(REG_DECAY_LEVEL, d);
    write_reg(REG_AMPLITUDE, g);
    write_reg(REG_HARMONIC_LIMIT, lim);
  endtask

  function automatic logic [30:0] pick_step();
    case ($urandom_range(5))
      0: return 31'($urandom);
      1: return 31'($urandom_range(1, 1 << 20));
      2: return 31'($urandom_range(1, 1 << 26));
      3: return 31'($urandom_range(0, 3));
      default: return 31'($urandom_range(1, 1 << 29));
    endcase
  endfunction

  task automatic random_notes(int count);
    int n, ticks;
    logic [23:0] nlen;
    n = 0;
    while (n < count) begin
      case ($urandom_range(9))
        0: nlen = 24'($urandom);
        1: nlen = 0;
        2: nlen = 24'(sb.attack_len + sb.release_len);
        default: nlen = 24'($urandom_range(1, 40));
      endcase
      send_word(1'b1, pick_step(), nlen);
      n++;
      ticks = (nlen > 40) ? $urandom_range(0, 12) : $urandom_range(0, nlen + 2);
      // noise: an occasional random word mid-note
      for (int t = 0; t < ticks && n < count; t++) begin
        if ($urandom_range(19) == 0) send_word(1'($urandom), 31'($urandom), 24'($urandom));
        else send_word(1'b0, 31'($urandom), 24'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: idle, zero length, extremes, restart while playing
    send_word(1'b0, 31'h7FFF_FFFF, 24'hFF_FFFF);
    send_word(1'b1, 31'h1234_5678, 24'd0);
    send_word(1'b1, 31'h7FFF_FFFF, 24'hFF_FFFF);
    send_word(1'b0, 31'd0, 24'd0);
    send_word(1'b1, 31'd0, 24'd3);
    repeat (3) send_word(1'b0, 31'd0, 24'd0);
    send_word(1'b1, 31'd1, 24'd2);
    send_word(1'b1, 31'h0100_0000, 24'd4);
    repeat (4) send_word(1'b0, 31'h5555_5555, 24'hAA_AAAA);
    drain();
    program_regs(3, 5, 65535, 32768, 32'hFFFF_FFFF);
    send_word(1'b1, 31'h0080_0000, 24'd8);
    repeat (8) send_word(1'b0, 31'd0, 24'd0);
    send_word(1'b1, 31'h0000_0001, 24'd1);
    send_word(1'b0, 31'd0, 24'd0);
    drain();

    program_regs(1, 1, 0, 65535, 32'h8000_0000);
    random_notes(75);
    drain();
    program_regs(4, 6, 32768, 32768, 32'hFFFF_FFFF);
    random_notes(75);
    drain();
    send_idle = 62; recv_idle = 17;
    program_regs(65535, 65535, 12000, 0, 0);
    random_notes(60);
    drain();
    program_regs($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(0, 32768),
                 $urandom_range(0, 32768), $urandom);
    random_notes(75);
    drain();
    send_idle = 0; recv_idle = 0;
    program_regs(2, 3, 20000, 30000, 32'h4000_0000);
    random_notes(120);
    drain();

    if (sb.errors == 0 && sb.sample_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end

endmodule
